// ----- hw/rtl/jerk_limited_jog_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Jog generator assertion macros
// Concurrent assertion wrappers. In synthesis builds they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef JERK_LIMITED_JOG_GENERATOR_DEFINES_SVH
`define JERK_LIMITED_JOG_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every rising edge while reset is released.
`define JLJ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jog generator assertion failed");
// Checked at every rising edge, reset included.
`define JLJ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("jog generator assertion failed");
`else
`define JLJ_ASSERT(lbl, clk, rst_n, prop)
`define JLJ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hw/rtl/jlj_pkg.sv -----
// ----------------------------------------------------------------------------
// Jog generator package
// Shared widths, register indexes, constants and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package jlj_pkg;

    // Default values of the top-level parameters.
    localparam int AXES_DEF      = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Field widths.
    localparam int AXIS_W   = 5;
    localparam int MOVE_W   = 16;
    localparam int ST_W     = 40;
    localparam int VMAX_W   = 32;
    localparam int LIMIT_W  = 31;

    // Stream and register port widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 104;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // Register indexes.
    localparam logic [1:0] REG_VMAX    = 2'd0;
    localparam logic [1:0] REG_MAX_ACC = 2'd1;
    localparam logic [1:0] REG_JERK    = 2'd2;

    localparam logic [LIMIT_W-1:0] JERK_RESET = 31'd65536;

    // Shared multiplier: 41-bit operand times one 8-bit digit per cycle.
    localparam int MUL_A_W    = 41;
    localparam int MUL_B_W    = 40;
    localparam int MUL_DIG_W  = 8;
    localparam int MUL_DIGITS = MUL_B_W / MUL_DIG_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic signed [VMAX_W-1:0] vmax;
        logic [LIMIT_W-1:0]       max_acc;
        logic [LIMIT_W-1:0]       jerk;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] op_a;
        logic [MUL_B_W-1:0] op_b;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_rsp;

endpackage

`default_nettype wire

// ----- hw/rtl/jlj_cfg.sv -----
// ----------------------------------------------------------------------------
// Jog generator register file
// APB-style port holding the target speed, acceleration limit and jerk.
// ----------------------------------------------------------------------------
`default_nettype none

module jlj_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [jlj_pkg::APB_AW-1:0] paddr,
    input  wire logic [jlj_pkg::APB_DW-1:0] pwdata,
    output logic      [jlj_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output jlj_pkg::t_cfg                   o_cfg
);
    import jlj_pkg::*;

    logic       wr_en;
    logic [1:0] reg_idx;
    t_cfg       r_cfg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Register writes; an address beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vmax    <= '0;
            r_cfg.max_acc <= '0;
            r_cfg.jerk    <= JERK_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_VMAX:    r_cfg.vmax    <= $signed(pwdata);
                REG_MAX_ACC: r_cfg.max_acc <= pwdata[LIMIT_W-1:0];
                REG_JERK:    r_cfg.jerk    <= pwdata[LIMIT_W-1:0];
                default:     r_cfg.vmax    <= r_cfg.vmax;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_idx)
            REG_VMAX:    prdata = r_cfg.vmax;
            REG_MAX_ACC: prdata = {1'b0, r_cfg.max_acc};
            REG_JERK:    prdata = {1'b0, r_cfg.jerk};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hw/rtl/jlj_ram.sv -----
// ----------------------------------------------------------------------------
// Axis state memory
// One write port and one registered read port for per-axis speed and accel.
// ----------------------------------------------------------------------------
`default_nettype none

module jlj_ram #(
    parameter  int DEPTH  = jlj_pkg::AXES_DEF,
    parameter  int WIDTH  = 2 * jlj_pkg::ST_W,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    import jlj_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/jlj_mult.sv -----
// ----------------------------------------------------------------------------
// Shared digit-serial multiplier
// Unsigned 41 x 40 bit product, one 8-bit digit of the second operand a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jlj_mult (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  jlj_pkg::t_mul_req                i_req,
    output jlj_pkg::t_mul_rsp                o_rsp,
    output logic     [jlj_pkg::MUL_P_W-1:0]  o_prod
);
    import jlj_pkg::*;

    localparam int CNT_W = $clog2(MUL_DIGITS + 1);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [MUL_A_W-1:0]           r_a;
    logic [MUL_B_W-1:0]           r_b;
    logic [MUL_P_W-1:0]           r_acc;
    logic [MUL_A_W+MUL_DIG_W-1:0] partial;
    logic [MUL_P_W-1:0]           n_acc;

    // Top digit of the second operand times the first, added to the shifted sum.
    assign partial = r_a * r_b[MUL_B_W-1 -: MUL_DIG_W];
    assign n_acc   = {r_acc[MUL_P_W-MUL_DIG_W-1:0], {MUL_DIG_W{1'b0}}}
                   + MUL_P_W'(partial);

    // Control: a start loads the operands, then one digit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MUL_DIGITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.op_a;
            r_b   <= i_req.op_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= {r_b[MUL_B_W-MUL_DIG_W-1:0], {MUL_DIG_W{1'b0}}};
            r_acc <= n_acc;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_prod     = r_acc;

endmodule

`default_nettype wire

// ----- hw/rtl/jerk_limited_jog_generator.sv -----
// ----------------------------------------------------------------------------
// Jerk-limited jog generator
// Per-axis S-curve jog profile driven by one servo tick per transaction.
// ----------------------------------------------------------------------------
// Usage: each slave transaction is one tick for one axis, tdata bits [4:0]
// the axis and bit [5] the jog request. An idle axis arms on a request and
// gives no result; an active axis steps its acceleration and speed and gives
// one master transaction, unless its speed turns negative on release, which
// sends it idle without a result. Ticks for axes beyond AXES are dropped.
// Registers (speed, acceleration limit, jerk) are written over the APB port
// while no tick is in flight.
// Timing: the block takes one tick at a time. Ticks that arm or are dropped
// leave the sequencer idle. A stepping tick runs from acceptance to the
// result register through the shared 41 x 8 multiplier, which forms each
// product digit by digit; a tick uses up to three products (squared
// acceleration, the jerk-times-distance bound, and the scaling of the position
// increment). A stalled receiver holds the result register; the next tick
// is accepted meanwhile and waits before its own result is loaded.
// Reset clears the registers to their defaults, marks every axis idle and
// empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "jerk_limited_jog_generator_defines.svh"

module jerk_limited_jog_generator #(
    parameter int AXES      = jlj_pkg::AXES_DEF,
    parameter int FRAC_BITS = jlj_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Ticks: [4:0] axis, [5] jog_request, [7:6] zero.
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [jlj_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Results: [4:0] out_axis, [20:5] move_counts, [60:21] accel_now,
    // [100:61] velocity_now, [103:101] zero.
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic      [jlj_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Register port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [jlj_pkg::APB_AW-1:0]      paddr,
    input  wire logic [jlj_pkg::APB_DW-1:0]      pwdata,
    output logic      [jlj_pkg::APB_DW-1:0]      prdata,
    output logic                                 pready
);
    import jlj_pkg::*;

    localparam int AIDX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int WIDE_W = ST_W + 2;
    localparam int SIX_W  = ST_W + 6;
    localparam int RECIP_IN_W  = 18;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_IN_W-1:0] RECIP = 18'd174763;
    localparam int SAT_Y = 6 * 32768;
    localparam logic [MOVE_W-1:0] MAG_SAT  = 16'h8000;
    localparam logic [MOVE_W-1:0] MOVE_MAX = 16'h7FFF;
    localparam logic signed [ST_W-1:0] MAX40 = {1'b0, {(ST_W-1){1'b1}}};
    localparam logic signed [ST_W-1:0] MIN40 = {1'b1, {(ST_W-1){1'b0}}};

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_READ   = 10'b0000000010,
        S_TEST   = 10'b0000000100,
        S_MSQ    = 10'b0000001000,
        S_MRH    = 10'b0000010000,
        S_DECIDE = 10'b0000100000,
        S_KIN    = 10'b0001000000,
        S_SCALE  = 10'b0010000000,
        S_MDIV   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        JS_ZERO = 2'd0,
        JS_POS  = 2'd1,
        JS_NEG  = 2'd2
    } t_jsign;

    function automatic logic signed [ST_W-1:0] sat40(input logic signed [WIDE_W-1:0] x);
        logic signed [ST_W-1:0] res;
        if (x[WIDE_W-1:ST_W-1] == '0 || x[WIDE_W-1:ST_W-1] == '1) begin
            res = x[ST_W-1:0];
        end else if (x[WIDE_W-1]) begin
            res = MIN40;
        end else begin
            res = MAX40;
        end
        return res;
    endfunction

    t_cfg                      cfg;
    t_mul_req                  mul_req;
    t_mul_rsp                  mul_rsp;
    logic [MUL_P_W-1:0]        mul_prod;

    t_state                    r_state;
    logic [AXES-1:0]           r_active;
    logic [AXES-1:0]           r_dir;
    logic [AXIS_W-1:0]         r_ax;
    logic [AIDX_W-1:0]         r_idx;
    logic                      r_req;
    logic signed [ST_W-1:0]    r_v;
    logic signed [ST_W-1:0]    r_a;
    logic signed [WIDE_W-1:0]  r_d;
    logic [MUL_P_W-1:0]        r_sq;
    logic                      r_exc;
    t_jsign                    r_sign;
    logic                      r_ysat;
    logic [RECIP_IN_W-1:0]     r_ylo;
    logic                      r_neg;
    logic [MOVE_W-1:0]         r_mag;
    logic                      r_ovalid;
    logic [OUT_TDATA_W-1:0]    r_odata;

    logic                      in_accept;
    logic [AXIS_W-1:0]         in_axis;
    logic                      in_req;
    logic [AXIS_W:0]           in_ax_ext;
    logic [AIDX_W-1:0]         in_idx;
    logic                      in_range;
    logic                      in_active;
    logic                      arm;
    logic                      go;
    logic [2*ST_W-1:0]         ram_rdata;
    logic                      ram_we;
    logic [AIDX_W-1:0]         ram_waddr;
    logic [2*ST_W-1:0]         ram_wdata;

    logic [VMAX_W-1:0]         lim;
    logic signed [WIDE_W-1:0]  v_w;
    logic signed [WIDE_W-1:0]  a_w;
    logic signed [WIDE_W-1:0]  j_w;
    logic signed [WIDE_W-1:0]  jh_w;
    logic signed [WIDE_W-1:0]  maxacc_w;
    logic signed [WIDE_W-1:0]  d_sel;
    logic                      need_test;
    logic [ST_W-1:0]           abs_a;
    logic                      test_mul;
    t_jsign                    n_sign;
    logic signed [WIDE_W-1:0]  sj;
    logic signed [WIDE_W-1:0]  sjh;
    logic signed [ST_W-1:0]    n_vel;
    logic signed [ST_W-1:0]    n_acc;
    logic signed [SIX_W-1:0]   six;
    logic [SIX_W-1:0]          abs_six;
    logic [SIX_W-1:0]          six_y;
    logic [MOVE_W-1:0]         n_counts;
    logic                      out_free;

    // Register port.
    jlj_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input decode.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept = i_s_axis_tvalid & o_s_axis_tready;
    assign in_axis   = i_s_axis_tdata[AXIS_W-1:0];
    assign in_req    = i_s_axis_tdata[AXIS_W];
    assign in_ax_ext = {1'b0, in_axis};
    assign in_idx    = in_ax_ext[AIDX_W-1:0];
    assign in_range  = 32'(in_ax_ext) < 32'(AXES);
    assign in_active = in_range & r_active[in_idx];
    assign arm = in_accept & in_range & in_req & ~r_active[in_idx];
    assign go  = in_accept & in_active;

    // Axis state store: arming zeroes the entry, the step writes it back.
    assign ram_we    = arm | (r_state == S_KIN);
    assign ram_waddr = arm ? in_idx : r_idx;
    assign ram_wdata = arm ? '0 : {n_vel, n_acc};

    jlj_ram #(
        .DEPTH (AXES),
        .WIDTH (2 * ST_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (go),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // Operands of the limit test.
    assign lim      = cfg.vmax[VMAX_W-1] ? VMAX_W'(-cfg.vmax) : cfg.vmax;
    assign v_w      = WIDE_W'(r_v);
    assign a_w      = WIDE_W'(r_a);
    assign j_w      = $signed({{(WIDE_W-LIMIT_W){1'b0}}, cfg.jerk});
    assign jh_w     = $signed({{(WIDE_W-LIMIT_W+1){1'b0}}, cfg.jerk[LIMIT_W-1:1]});
    assign maxacc_w = $signed({{(WIDE_W-LIMIT_W){1'b0}}, cfg.max_acc});
    assign d_sel    = r_req ? ($signed({{(WIDE_W-VMAX_W){1'b0}}, lim}) - v_w) : v_w;
    assign need_test = r_req | r_a[ST_W-1];
    assign abs_a    = r_a[ST_W-1] ? ST_W'(-r_a) : r_a;
    assign test_mul = need_test & (cfg.jerk != '0) & (d_sel != '0) & ~d_sel[WIDE_W-1];

    // Shared multiplier requests.
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.op_a  = MUL_A_W'(abs_a);
        mul_req.op_b  = MUL_B_W'(abs_a);
        case (r_state)
            S_TEST: begin
                mul_req.start = test_mul;
            end
            S_MSQ: begin
                mul_req.start = mul_rsp.done;
                mul_req.op_a  = r_d[MUL_A_W-1:0];
                mul_req.op_b  = MUL_B_W'({cfg.jerk, 1'b0});
            end
            S_SCALE: begin
                mul_req.start = ~r_ysat;
                mul_req.op_a  = MUL_A_W'(r_ylo);
                mul_req.op_b  = MUL_B_W'(RECIP);
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    jlj_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp),
        .o_prod  (mul_prod)
    );

    // Jerk sign for this tick.
    always_comb begin
        if (r_req) begin
            if (r_exc) begin
                n_sign = ((a_w - j_w) < 0) ? JS_ZERO : JS_NEG;
            end else if (a_w < maxacc_w) begin
                n_sign = JS_POS;
            end else begin
                n_sign = JS_ZERO;
            end
        end else begin
            if (!r_a[ST_W-1]) begin
                n_sign = JS_NEG;
            end else if (r_exc) begin
                n_sign = JS_POS;
            end else if (a_w > -maxacc_w) begin
                n_sign = JS_NEG;
            end else begin
                n_sign = JS_ZERO;
            end
        end
    end

    // One tick of motion and the exact six-fold increment.
    always_comb begin
        case (r_sign)
            JS_POS: begin
                sj  = j_w;
                sjh = jh_w;
            end
            JS_NEG: begin
                sj  = -j_w;
                sjh = -jh_w;
            end
            default: begin
                sj  = '0;
                sjh = '0;
            end
        endcase
    end

    assign n_vel   = sat40(v_w + a_w + sjh);
    assign n_acc   = sat40(a_w + sj);
    assign six     = (SIX_W'(r_v) <<< 2) + (SIX_W'(r_v) <<< 1)
                   + (SIX_W'(r_a) <<< 1) + SIX_W'(r_a) + SIX_W'(sj);
    assign abs_six = six[SIX_W-1] ? SIX_W'(-six) : six;
    assign six_y   = abs_six >> FRAC_BITS;

    // Signed, saturated whole-count increment.
    assign n_counts = r_neg ? MOVE_W'(~r_mag + 1'b1)
                            : (r_mag[MOVE_W-1] ? MOVE_MAX : r_mag);
    assign out_free = ~r_ovalid | i_m_axis_tready;

    // Sequencer and per-axis flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_dir    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (arm) begin
                        r_active[in_idx] <= 1'b1;
                        r_dir[in_idx]    <= cfg.vmax[VMAX_W-1];
                    end
                    if (go) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    r_state <= test_mul ? S_MSQ : S_DECIDE;
                end
                S_MSQ: begin
                    if (mul_rsp.done) begin
                        r_state <= S_MRH;
                    end
                end
                S_MRH: begin
                    if (mul_rsp.done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_KIN;
                end
                S_KIN: begin
                    if (!r_req && n_vel[ST_W-1]) begin
                        r_active[r_idx] <= 1'b0;
                        r_state         <= S_IDLE;
                    end else begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state <= r_ysat ? S_OUT : S_MDIV;
                end
                S_MDIV: begin
                    if (mul_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ax  <= in_axis;
                r_idx <= in_idx;
                r_req <= in_req;
            end
            S_READ: begin
                r_v <= ram_rdata[2*ST_W-1:ST_W];
                r_a <= ram_rdata[ST_W-1:0];
            end
            S_TEST: begin
                r_d <= d_sel;
                if (!need_test) begin
                    r_exc <= 1'b0;
                end else if (cfg.jerk == '0 || d_sel == '0) begin
                    r_exc <= (r_a != '0);
                end else begin
                    r_exc <= 1'b1;
                end
            end
            S_MSQ: begin
                r_sq <= mul_prod;
            end
            S_MRH: begin
                r_exc <= (r_sq > mul_prod);
            end
            S_DECIDE: begin
                r_sign <= n_sign;
            end
            S_KIN: begin
                r_v    <= n_vel;
                r_a    <= n_acc;
                r_ysat <= (six_y >= SIX_W'(SAT_Y));
                r_ylo  <= six_y[RECIP_IN_W-1:0];
                r_neg  <= six[SIX_W-1] ^ r_dir[r_idx];
            end
            S_SCALE: begin
                r_mag <= MAG_SAT;
            end
            S_MDIV: begin
                r_mag <= mul_prod[RECIP_SHIFT +: MOVE_W];
            end
            S_OUT: begin
                if (out_free) begin
                    r_odata <= {3'b000, r_v, r_a, n_counts, r_ax};
                end
            end
            default: begin
                r_ax <= r_ax;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // The multiplier is only started when it is free.
    `JLJ_ASSERT(a_mul_start_free, i_clk, i_rst_n, mul_req.start |-> !mul_rsp.busy)
    // A finished product is only ever seen by a state that waits for it.
    `JLJ_ASSERT(a_mul_done_waited, i_clk, i_rst_n, mul_rsp.done |-> (r_state == S_MSQ || r_state == S_MRH || r_state == S_MDIV))
    // A new result only comes from the output state.
    `JLJ_ASSERT(a_out_from_seq, i_clk, i_rst_n, $rose(o_m_axis_tvalid) |-> $past(r_state) == S_OUT)
    // A tick for a missing axis causes no work.
    `JLJ_ASSERT(a_bad_axis_dropped, i_clk, i_rst_n, (in_accept && !in_range) |=> r_state == S_IDLE)
    // Reset empties the result register.
    `JLJ_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

`default_nettype wire

// ----- test/tb_jerk_limited_jog_generator.sv -----
// ----------------------------------------------------------------------------
// Jog generator testbench
// Sends servo ticks over the slave stream and rewrites the speed, acceleration
// and jerk registers over APB between phases. A local S-curve model predicts
// every motion result, and each result on the master stream is checked
// field by field. Handshake pacing varies from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_jerk_limited_jog_generator;

    import jlj_pkg::*;

    localparam int    NUM_AXES  = AXES_DEF;
    localparam longint TICK_DIV = longint'(6) << FRAC_BITS_DEF;
    localparam longint ST_MAX   = 64'sd549755813887;
    localparam longint ST_MIN   = -64'sd549755813888;
    // Index with no register behind it; writes there must change nothing.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum int {JERK_DOWN = -1, JERK_HOLD = 0, JERK_UP = 1} jerk_dir_t;
    typedef enum {PACE_STEADY, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pacing_t;

    // Result fields, last field in the lowest bits.
    typedef struct packed {
        logic signed [ST_W-1:0]   velocity;
        logic signed [ST_W-1:0]   accel;
        logic signed [MOVE_W-1:0] move;
        logic [AXIS_W-1:0]        axis;
    } jog_move_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    jerk_limited_jog_generator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Shadow registers and per-axis profile state.
    int                 vmax_r    = 0;
    logic [LIMIT_W-1:0] max_acc_r = '0;
    logic [LIMIT_W-1:0] jerk_r    = JERK_RESET;
    bit                 axis_on    [NUM_AXES];
    bit                 axis_rev   [NUM_AXES];
    longint             axis_vel   [NUM_AXES];
    longint             axis_acc   [NUM_AXES];
    int                 hold_left  [NUM_AXES];

    jog_move_t expected_moves[$];
    int        send_gap_pct   = 0;
    int        recv_stall_pct = 0;
    int        mismatches     = 0;
    int        ticks_sent     = 0;
    int        moves_checked  = 0;
    int        settings_used  = 0;
    jog_move_t seen_move;
    jog_move_t due_move;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: ready drops at random per the current pacing.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch at %0t ns: %s", $realtime, msg);
        end
    endtask

    // Compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_move = jog_move_t'(o_m_axis_tdata[$bits(jog_move_t)-1:0]);
            moves_checked++;
            if (expected_moves.size() == 0) begin
                note_mismatch($sformatf("unexpected result axis %0d move %0d accel %0d vel %0d",
                    seen_move.axis, seen_move.move, seen_move.accel, seen_move.velocity));
            end else begin
                due_move = expected_moves.pop_front();
                if (seen_move.axis !== due_move.axis || seen_move.move !== due_move.move ||
                    seen_move.accel !== due_move.accel ||
                    seen_move.velocity !== due_move.velocity) begin
                    note_mismatch($sformatf(
                        "expected axis %0d move %0d accel %0d vel %0d, got %0d %0d %0d %0d",
                        due_move.axis, due_move.move, due_move.accel, due_move.velocity,
                        seen_move.axis, seen_move.move, seen_move.accel,
                        seen_move.velocity));
                end
            end
        end
    end

    function automatic longint clamp40(input longint x);
        if (x > ST_MAX) return ST_MAX;
        if (x < ST_MIN) return ST_MIN;
        return x;
    endfunction

    // Exact test of a*a > 2*j*d; with zero jerk or distance it reduces to a != 0.
    function automatic bit accel_overshoots(input longint a, input longint unsigned j,
                                            input longint d);
        longint unsigned ua;
        longint unsigned ud;
        logic [127:0]    lhs;
        logic [127:0]    rhs;
        if (j == 0 || d == 0) return (a != 0);
        if (d < 0) return 1'b1;
        ua  = (a < 0) ? -a : a;
        ud  = d;
        lhs = 128'(ua) * 128'(ua);
        rhs = 128'(2 * j) * 128'(ud);
        return (lhs > rhs);
    endfunction

    // One tick of motion with the given jerk direction; returns whole counts moved.
    function automatic logic signed [MOVE_W-1:0] advance_axis(input int ax,
                                                              input jerk_dir_t dir);
        longint v;
        longint a;
        longint j;
        longint jh;
        longint cnt;
        v   = axis_vel[ax];
        a   = axis_acc[ax];
        j   = longint'(jerk_r);
        jh  = longint'(jerk_r >> 1);
        cnt = (6 * v + 3 * a + longint'(dir) * j) / TICK_DIV;
        axis_vel[ax] = clamp40(v + a + longint'(dir) * jh);
        axis_acc[ax] = clamp40(a + longint'(dir) * j);
        if (axis_rev[ax]) cnt = -cnt;
        if (cnt > 32767) cnt = 32767;
        if (cnt < -32768) cnt = -32768;
        return cnt[MOVE_W-1:0];
    endfunction

    // Profile state machine for one tick; has_move says whether a result is due.
    function automatic void predict_tick(input int ax, input bit req, output bit has_move,
                                         output jog_move_t mv);
        longint lim;
        longint a;
        longint v;
        longint j;
        logic signed [MOVE_W-1:0] cnt;
        has_move = 1'b0;
        mv       = '0;
        lim = (vmax_r < 0) ? -longint'(vmax_r) : longint'(vmax_r);
        j   = longint'(jerk_r);
        a   = axis_acc[ax];
        v   = axis_vel[ax];
        if (req) begin
            if (!axis_on[ax]) begin
                // Arming tick: take direction, start from rest, no result.
                axis_rev[ax] = (vmax_r < 0);
                axis_vel[ax] = 0;
                axis_acc[ax] = 0;
                axis_on[ax]  = 1'b1;
                return;
            end
            if (accel_overshoots(a, jerk_r, lim - v)) begin
                cnt = (a - j < 0) ? advance_axis(ax, JERK_HOLD) : advance_axis(ax, JERK_DOWN);
            end else if (a < longint'(max_acc_r)) begin
                cnt = advance_axis(ax, JERK_UP);
            end else begin
                cnt = advance_axis(ax, JERK_HOLD);
            end
        end else begin
            if (!axis_on[ax]) return;
            if (a >= 0) begin
                cnt = advance_axis(ax, JERK_DOWN);
            end else if (accel_overshoots(a, jerk_r, v)) begin
                cnt = advance_axis(ax, JERK_UP);
            end else if (a > -longint'(max_acc_r)) begin
                cnt = advance_axis(ax, JERK_DOWN);
            end else begin
                cnt = advance_axis(ax, JERK_HOLD);
            end
            // Stop tick: speed went below zero, axis goes idle silently.
            if (axis_vel[ax] < 0) begin
                axis_on[ax] = 1'b0;
                return;
            end
        end
        has_move    = 1'b1;
        mv.axis     = ax[AXIS_W-1:0];
        mv.move     = cnt;
        mv.accel    = axis_acc[ax][ST_W-1:0];
        mv.velocity = axis_vel[ax][ST_W-1:0];
    endfunction

    // Send one tick transaction; starts and returns at a falling edge, valid left high.
    task automatic send_tick(input int ax, input bit req);
        bit        has_move;
        jog_move_t mv;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, req, ax[AXIS_W-1:0]};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_tick(ax, req, has_move, mv);
        if (has_move) expected_moves.push_back(mv);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every result is back and silent ticks have drained.
    task automatic wait_quiet();
        i_s_axis_tvalid <= 1'b0;
        while (expected_moves.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // One APB transfer: setup, access, then back to idle.
    task automatic apb_transfer(input bit wr, input logic [1:0] idx,
                                input logic [APB_DW-1:0] wdata,
                                output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (wr) begin
            case (idx)
                REG_VMAX:    vmax_r    = wdata;
                REG_MAX_ACC: max_acc_r = wdata[LIMIT_W-1:0];
                REG_JERK:    jerk_r    = wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back(input logic [1:0] idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] got;
        logic [APB_DW-1:0] mask;
        apb_transfer(1'b0, idx, '0, got);
        mask = (idx == REG_VMAX) ? '1 : {1'b0, {LIMIT_W{1'b1}}};
        if ((got & mask) !== (want & mask)) begin
            note_mismatch($sformatf("register %0d read %h, expected %h", idx, got, want));
        end
    endtask

    task automatic program_settings(input int vm, input logic [LIMIT_W-1:0] ma,
                                    input logic [LIMIT_W-1:0] jk);
        logic [APB_DW-1:0] unused;
        wait_quiet();
        apb_transfer(1'b1, REG_VMAX, vm, unused);
        apb_transfer(1'b1, REG_MAX_ACC, {1'b0, ma}, unused);
        apb_transfer(1'b1, REG_JERK, {1'b0, jk}, unused);
        settings_used++;
    endtask

    task automatic set_pacing(input pacing_t p);
        case (p)
            PACE_STEADY:          begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            PACE_SENDER_GAPS:     begin send_gap_pct = 47; recv_stall_pct = 0;  end
            PACE_RECEIVER_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 47; end
            default:              begin send_gap_pct = 10; recv_stall_pct = 10; end
        endcase
    endtask

    // Random settings whose profiles reach top speed and stop within tens of ticks.
    task automatic pick_jog_settings(output int vm, output logic [LIMIT_W-1:0] ma,
                                     output logic [LIMIT_W-1:0] jk);
        longint span;
        span = longint'($urandom_range(1, 300)) * 65536 + $urandom_range(0, 65535);
        ma   = span / $urandom_range(4, 40) + 1;
        jk   = ma / $urandom_range(1, 12) + 1;
        vm   = $urandom_range(0, 1) ? -span : span;
    endtask

    // Whole jog cycles on a few axes (arm, hold, release to stop) mixed with noise.
    task automatic run_jogs(input int n);
        int pool[3];
        int ax;
        bit req;
        foreach (pool[k]) pool[k] = $urandom_range(0, NUM_AXES - 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 12) begin
                ax  = $urandom_range(0, NUM_AXES - 1);
                req = $urandom_range(0, 1);
            end else begin
                ax = pool[$urandom_range(0, 2)];
                if (!axis_on[ax]) begin
                    hold_left[ax] = $urandom_range(2, 40);
                    req = 1'b1;
                end else if (hold_left[ax] > 0) begin
                    hold_left[ax]--;
                    req = 1'b1;
                end else begin
                    // Mostly decelerate; now and then request again mid-stop.
                    req = ($urandom_range(0, 99) < 3);
                end
            end
            send_tick(ax, req);
            if (i == n / 2) wait_quiet();
        end
    endtask

    // Reset values, read back of every register, and the write to an unused index.
    task automatic test_register_access();
        logic [APB_DW-1:0] unused;
        read_back(REG_VMAX, '0);
        read_back(REG_MAX_ACC, '0);
        read_back(REG_JERK, {1'b0, JERK_RESET});
        apb_transfer(1'b1, REG_UNUSED, 32'hFFFF_FFFF, unused);
        read_back(REG_VMAX, '0);
        read_back(REG_MAX_ACC, '0);
        read_back(REG_JERK, {1'b0, JERK_RESET});
    endtask

    // Short directed sequences around each special case.
    task automatic test_directed();
        logic [APB_DW-1:0] unused;
        // Reset settings: release while idle, arming, coasting at zero, stop tick.
        send_tick(7, 1'b0);
        send_tick(7, 1'b1);
        send_tick(7, 1'b1);
        send_tick(7, 1'b0);
        // Largest settings on the top axis: increment saturates high.
        program_settings(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        read_back(REG_VMAX, 32'h7FFF_FFFF);
        read_back(REG_MAX_ACC, 32'h7FFF_FFFF);
        read_back(REG_JERK, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++) send_tick(31, 1'b1);
        for (int i = 0; i < 4 && axis_on[31]; i++) send_tick(31, 1'b0);
        // Most negative speed on axis zero: reversed direction, saturates low.
        wait_quiet();
        apb_transfer(1'b1, REG_VMAX, 32'h8000_0000, unused);
        for (int i = 0; i < 4; i++) send_tick(0, 1'b1);
        for (int i = 0; i < 4 && axis_on[0]; i++) send_tick(0, 1'b0);
        // Zero jerk with an axis already accelerating.
        program_settings(50 * 65536, 3 * 65536, 65536);
        for (int i = 0; i < 3; i++) send_tick(21, 1'b1);
        wait_quiet();
        apb_transfer(1'b1, REG_JERK, '0, unused);
        read_back(REG_JERK, '0);
        send_tick(21, 1'b1);
        send_tick(21, 1'b0);
        send_tick(21, 1'b0);
        wait_quiet();
    endtask

    // Random jog cycles under random settings, one pacing mode per phase.
    task automatic test_random_jogs();
        int                 vm;
        logic [LIMIT_W-1:0] ma;
        logic [LIMIT_W-1:0] jk;
        for (int p = 0; p < 4; p++) begin
            pick_jog_settings(vm, ma, jk);
            program_settings(vm, ma, jk);
            set_pacing(pacing_t'(p));
            run_jogs(230);
        end
    endtask

    // Settings at and near the register limits.
    task automatic test_extreme_settings();
        program_settings(32'sh8000_0000, 31'h7FFF_FFFF, $urandom_range(31'h4000_0000, 31'h7FFF_FFFF));
        set_pacing(PACE_STEADY);
        run_jogs(120);
        program_settings(32'h7FFF_FFFF, 512 * 65536, 64 * 65536);
        set_pacing(PACE_RECEIVER_STALLS);
        run_jogs(120);
        // Smallest nonzero jerk and tiny limits.
        program_settings(-40, 6, 1);
        set_pacing(PACE_BOTH);
        run_jogs(120);
        // No acceleration allowed: held axes coast, releases stop them.
        program_settings(20 * 65536, 0, 4096);
        set_pacing(PACE_SENDER_GAPS);
        run_jogs(100);
    endtask

    // Stimulus sequence.
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_register_access();
        test_directed();
        test_random_jogs();
        test_extreme_settings();
        wait_quiet();

        $display("Ran %0d ticks across %0d axes under %0d register settings.",
                 ticks_sent, NUM_AXES, settings_used);
        $display("Checked %0d motion results over four pacing modes; %0d mismatches.",
                 moves_checked, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- jerk_limited_jog_generator.f -----
+incdir+hw/rtl
hw/rtl/jlj_pkg.sv
hw/rtl/jlj_cfg.sv
hw/rtl/jlj_ram.sv
hw/rtl/jlj_mult.sv
hw/rtl/jerk_limited_jog_generator.sv
test/tb_jerk_limited_jog_generator.sv
